// ===== rtl/obb_pkg.sv =====
// ---------------------------------------------------------------------------
// obb_pkg: shared constants for the oriented box overlap pipeline
// Field widths, default number formats and square root stage partitioning.
// ---------------------------------------------------------------------------
package obb_pkg;

    // every input field is three packed components in a 48-bit word
    localparam int FIELD_W = 48;
    // fields are zero extended to this width before components are picked
    localparam int EXT_W = 64;

    localparam int COORD_WIDTH_DEFAULT    = 16;
    localparam int AXIS_FRAC_BITS_DEFAULT = 14;

    // root bits resolved per square root pipeline stage
    localparam int SQRT_STEPS_PER_STAGE = 4;

endpackage

// ===== rtl/obb_obb_separating_axis_test.sv =====
// ---------------------------------------------------------------------------
// obb_obb_separating_axis_test: oriented box pair overlap, 15-axis test
// Pipelined separating axis test over 6 face axes and 9 cross axes.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  item     | item_valid / item_stall    | first_* and second_* box fields
//  result   | result_valid / result_stall| overlap
//
//  One box pair enters per clock and a result leaves per clock while no
//  finished result is held by result_stall. The pipeline depth is set by the
//  pipelined square root of the face axis lengths: W + 1 root bits, four per
//  stage. rst_n clears only the valid bits of the pipeline; data registers
//  are left as they are. When a finished result is held by result_stall the
//  whole pipeline freezes and item_stall is raised, so no transfer is lost
//  or repeated; empty slots keep advancing while the output is free.
//
module obb_obb_separating_axis_test #(
    parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEFAULT,
    parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [obb_pkg::FIELD_W-1:0] first_center,
    input  logic [obb_pkg::FIELD_W-1:0] first_axis_x,
    input  logic [obb_pkg::FIELD_W-1:0] first_axis_y,
    input  logic [obb_pkg::FIELD_W-1:0] first_axis_z,
    input  logic [obb_pkg::FIELD_W-1:0] first_half_size,
    input  logic [obb_pkg::FIELD_W-1:0] second_center,
    input  logic [obb_pkg::FIELD_W-1:0] second_axis_x,
    input  logic [obb_pkg::FIELD_W-1:0] second_axis_y,
    input  logic [obb_pkg::FIELD_W-1:0] second_axis_z,
    input  logic [obb_pkg::FIELD_W-1:0] second_half_size,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        overlap
);

    localparam int W         = COORD_WIDTH;
    localparam int F         = AXIS_FRAC_BITS;
    localparam int DW        = 2 * W + 2;
    localparam int DAW       = 2 * W + 3;
    localparam int CW        = (2 * W + 1 > F) ? 2 * W + 1 - F : 1;
    localparam int ROOT_W    = W + 1;
    localparam int STEPS     = obb_pkg::SQRT_STEPS_PER_STAGE;
    localparam int SQ_STAGES = (ROOT_W + STEPS - 1) / STEPS;
    localparam int DEPTH     = SQ_STAGES + 6;

    // ---------------------------------------------------------------- control
    logic             en;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    // advance whenever the output slot is empty or being taken
    assign en         = !valid_reg[DEPTH-1] || !result_stall;
    assign item_stall = !en;
    assign valid_next = {valid_reg[DEPTH-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg[DEPTH-1];

    // ---------------------------------------------------------- stage 1: unpack
    logic [obb_pkg::FIELD_W-1:0] field    [10];
    logic [obb_pkg::EXT_W-1:0]   ext_word [10];

    assign field[0] = first_center;
    assign field[1] = first_axis_x;
    assign field[2] = first_axis_y;
    assign field[3] = first_axis_z;
    assign field[4] = first_half_size;
    assign field[5] = second_center;
    assign field[6] = second_axis_x;
    assign field[7] = second_axis_y;
    assign field[8] = second_axis_z;
    assign field[9] = second_half_size;

    logic signed [W-1:0] ctr_a [3];
    logic signed [W-1:0] ctr_b [3];
    logic signed [W-1:0] a_next [3][3];
    logic signed [W-1:0] b_next [3][3];
    logic signed [W:0]   d_next [3];
    logic [W-1:0]        sa_next [3];
    logic [W-1:0]        sb_next [3];

    always_comb
    begin
        for (int n = 0; n < 10; n++)
        begin
            ext_word[n] = obb_pkg::EXT_W'(field[n]);
        end
        for (int k = 0; k < 3; k++)
        begin
            ctr_a[k]   = $signed(ext_word[0][k*W +: W]);
            ctr_b[k]   = $signed(ext_word[5][k*W +: W]);
            d_next[k]  = (W+1)'(ctr_a[k]) - (W+1)'(ctr_b[k]);
            sa_next[k] = ext_word[4][k*W +: W];
            sb_next[k] = ext_word[9][k*W +: W];
            for (int i = 0; i < 3; i++)
            begin
                a_next[i][k] = $signed(ext_word[1+i][k*W +: W]);
                b_next[i][k] = $signed(ext_word[6+i][k*W +: W]);
            end
        end
    end

    logic signed [W-1:0] a_s1_reg [3][3];
    logic signed [W-1:0] b_s1_reg [3][3];
    logic signed [W:0]   d_s1_reg [3];
    logic [W-1:0]        sa_s1_reg [3];
    logic [W-1:0]        sb_s1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_s1_reg  <= a_next;
            b_s1_reg  <= b_next;
            d_s1_reg  <= d_next;
            sa_s1_reg <= sa_next;
            sb_s1_reg <= sb_next;
        end
    end

    // ------------------------------------------------------- stage 2: products
    logic signed [2*W-1:0] ab_p_next [3][3][3];
    logic signed [2*W-1:0] aa_p_next [3][3];
    logic signed [2*W-1:0] bb_p_next [3][3];
    logic signed [2*W:0]   da_p_next [3][3];
    logic signed [2*W:0]   db_p_next [3][3];
    logic signed [2*W-1:0] cr_p_next [3][3][6];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                aa_p_next[i][m] = (2*W)'(a_s1_reg[i][m]) * (2*W)'(a_s1_reg[i][m]);
                bb_p_next[i][m] = (2*W)'(b_s1_reg[i][m]) * (2*W)'(b_s1_reg[i][m]);
                da_p_next[i][m] = (2*W+1)'(d_s1_reg[m]) * (2*W+1)'(a_s1_reg[i][m]);
                db_p_next[i][m] = (2*W+1)'(d_s1_reg[m]) * (2*W+1)'(b_s1_reg[i][m]);
                for (int k = 0; k < 3; k++)
                begin
                    ab_p_next[i][k][m] = (2*W)'(a_s1_reg[i][m]) * (2*W)'(b_s1_reg[k][m]);
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                cr_p_next[i][j][0] = (2*W)'(a_s1_reg[i][1]) * (2*W)'(b_s1_reg[j][2]);
                cr_p_next[i][j][1] = (2*W)'(a_s1_reg[i][2]) * (2*W)'(b_s1_reg[j][1]);
                cr_p_next[i][j][2] = (2*W)'(a_s1_reg[i][2]) * (2*W)'(b_s1_reg[j][0]);
                cr_p_next[i][j][3] = (2*W)'(a_s1_reg[i][0]) * (2*W)'(b_s1_reg[j][2]);
                cr_p_next[i][j][4] = (2*W)'(a_s1_reg[i][0]) * (2*W)'(b_s1_reg[j][1]);
                cr_p_next[i][j][5] = (2*W)'(a_s1_reg[i][1]) * (2*W)'(b_s1_reg[j][0]);
            end
        end
    end

    logic signed [2*W-1:0] ab_p_reg [3][3][3];
    logic signed [2*W-1:0] aa_p_reg [3][3];
    logic signed [2*W-1:0] bb_p_reg [3][3];
    logic signed [2*W:0]   da_p_reg [3][3];
    logic signed [2*W:0]   db_p_reg [3][3];
    logic signed [2*W-1:0] cr_p_reg [3][3][6];
    logic signed [W-1:0]   a_s2_reg [3][3];
    logic signed [W-1:0]   b_s2_reg [3][3];
    logic signed [W:0]     d_s2_reg [3];
    logic [W-1:0]          sa_s2_reg [3];
    logic [W-1:0]          sb_s2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_p_reg  <= ab_p_next;
            aa_p_reg  <= aa_p_next;
            bb_p_reg  <= bb_p_next;
            da_p_reg  <= da_p_next;
            db_p_reg  <= db_p_next;
            cr_p_reg  <= cr_p_next;
            a_s2_reg  <= a_s1_reg;
            b_s2_reg  <= b_s1_reg;
            d_s2_reg  <= d_s1_reg;
            sa_s2_reg <= sa_s1_reg;
            sb_s2_reg <= sb_s1_reg;
        end
    end

    // ------------------------------------------- stage 3: dots and cross axes
    logic signed [DW-1:0]  ab_next [3][3];
    logic [DW-1:0]         aa_next [3];
    logic [DW-1:0]         bb_next [3];
    logic signed [DAW-1:0] da_next [3];
    logic signed [DAW-1:0] db_next [3];
    logic signed [CW-1:0]  c_next  [3][3][3];

    always_comb
    begin
        logic signed [2*W:0] cdiff;
        cdiff = '0;
        for (int i = 0; i < 3; i++)
        begin
            aa_next[i] = DW'(aa_p_reg[i][0]) + DW'(aa_p_reg[i][1]) + DW'(aa_p_reg[i][2]);
            bb_next[i] = DW'(bb_p_reg[i][0]) + DW'(bb_p_reg[i][1]) + DW'(bb_p_reg[i][2]);
            da_next[i] = DAW'(da_p_reg[i][0]) + DAW'(da_p_reg[i][1]) + DAW'(da_p_reg[i][2]);
            db_next[i] = DAW'(db_p_reg[i][0]) + DAW'(db_p_reg[i][1]) + DAW'(db_p_reg[i][2]);
            for (int k = 0; k < 3; k++)
            begin
                ab_next[i][k] = DW'(ab_p_reg[i][k][0]) + DW'(ab_p_reg[i][k][1])
                              + DW'(ab_p_reg[i][k][2]);
            end
            // arithmetic shift gives the floor of the scaled cross product
            for (int j = 0; j < 3; j++)
            begin
                for (int m = 0; m < 3; m++)
                begin
                    cdiff = (2*W+1)'(cr_p_reg[i][j][2*m]) - (2*W+1)'(cr_p_reg[i][j][2*m+1]);
                    c_next[i][j][m] = CW'(cdiff >>> F);
                end
            end
        end
    end

    logic signed [DW-1:0]  ab_reg [3][3];
    logic [DW-1:0]         aa_reg [3];
    logic [DW-1:0]         bb_reg [3];
    logic signed [DAW-1:0] da_reg [3];
    logic signed [DAW-1:0] db_reg [3];
    logic signed [CW-1:0]  c_reg  [3][3][3];
    logic signed [W-1:0]   a_s3_reg [3][3];
    logic signed [W-1:0]   b_s3_reg [3][3];
    logic signed [W:0]     d_s3_reg [3];
    logic [W-1:0]          sa_s3_reg [3];
    logic [W-1:0]          sb_s3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_reg    <= ab_next;
            aa_reg    <= aa_next;
            bb_reg    <= bb_next;
            da_reg    <= da_next;
            db_reg    <= db_next;
            c_reg     <= c_next;
            a_s3_reg  <= a_s2_reg;
            b_s3_reg  <= b_s2_reg;
            d_s3_reg  <= d_s2_reg;
            sa_s3_reg <= sa_s2_reg;
            sb_s3_reg <= sb_s2_reg;
        end
    end

    // ------------------------------------------------------------- face axes
    logic [5:0] face_sep;

    generate
        for (genvar i = 0; i < 3; i++)
        begin : g_face
            logic signed [DW-1:0] dots_a [3];
            logic signed [DW-1:0] dots_b [3];

            always_comb
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dots_a[k] = ab_reg[i][k];
                    dots_b[k] = ab_reg[k][i];
                end
            end

            obb_face_axis #(.W(W), .F(F)) u_face_a (
                .clk         (clk),
                .en          (en),
                .dots        (dots_a),
                .sizes       (sb_s3_reg),
                .own_size    (sa_s3_reg[i]),
                .norm_sq     (aa_reg[i]),
                .center_proj (da_reg[i]),
                .sep         (face_sep[i])
            );

            obb_face_axis #(.W(W), .F(F)) u_face_b (
                .clk         (clk),
                .en          (en),
                .dots        (dots_b),
                .sizes       (sa_s3_reg),
                .own_size    (sb_s3_reg[i]),
                .norm_sq     (bb_reg[i]),
                .center_proj (db_reg[i]),
                .sep         (face_sep[3+i])
            );
        end
    endgenerate

    // ------------------------------------------------------------ cross axes
    logic [8:0] cross_sep;
    logic [8:0] cross_sep_dly;

    generate
        for (genvar i = 0; i < 3; i++)
        begin : g_cross_a
            for (genvar j = 0; j < 3; j++)
            begin : g_cross_b
                // the edges of each box other than the crossed one
                localparam int KA0 = (i == 0) ? 1 : 0;
                localparam int KA1 = (i == 2) ? 1 : 2;
                localparam int KB0 = (j == 0) ? 1 : 0;
                localparam int KB1 = (j == 2) ? 1 : 2;

                logic signed [CW-1:0] c_sel    [3];
                logic signed [W-1:0]  edge_sel [4][3];
                logic [W-1:0]         size_sel [4];

                always_comb
                begin
                    for (int m = 0; m < 3; m++)
                    begin
                        c_sel[m]       = c_reg[i][j][m];
                        edge_sel[0][m] = a_s3_reg[KA0][m];
                        edge_sel[1][m] = a_s3_reg[KA1][m];
                        edge_sel[2][m] = b_s3_reg[KB0][m];
                        edge_sel[3][m] = b_s3_reg[KB1][m];
                    end
                    size_sel[0] = sa_s3_reg[KA0];
                    size_sel[1] = sa_s3_reg[KA1];
                    size_sel[2] = sb_s3_reg[KB0];
                    size_sel[3] = sb_s3_reg[KB1];
                end

                obb_cross_axis #(.W(W), .F(F)) u_cross (
                    .clk   (clk),
                    .en    (en),
                    .c     (c_sel),
                    .edges (edge_sel),
                    .d     (d_s3_reg),
                    .sizes (size_sel),
                    .sep   (cross_sep[3*i+j])
                );
            end
        end
    endgenerate

    // hold cross results until the face results leave the square root
    obb_delay #(.WIDTH(9), .DEPTH(SQ_STAGES - 2)) u_cross_dly (
        .clk  (clk),
        .en   (en),
        .din  (cross_sep),
        .dout (cross_sep_dly)
    );

    // ---------------------------------------------------------- final stage
    logic overlap_next;
    logic overlap_reg;

    // overlap only when no axis separates the boxes
    assign overlap_next = !((|face_sep) || (|cross_sep_dly));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign overlap = overlap_reg;

endmodule

// ===== rtl/obb_delay.sv =====
// ---------------------------------------------------------------------------
// obb_delay: enable-gated delay line
// Passes a word through DEPTH enable-gated registers; passes it straight on at depth 0.
// ---------------------------------------------------------------------------
module obb_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    generate
        if (DEPTH == 0)
        begin : g_pass
            assign dout = din;
        end
        else
        begin : g_line
            logic [WIDTH-1:0] line_reg [DEPTH];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    line_reg[0] <= din;
                    for (int t = 1; t < DEPTH; t++)
                    begin
                        line_reg[t] <= line_reg[t-1];
                    end
                end
            end

            assign dout = line_reg[DEPTH-1];
        end
    endgenerate

endmodule

// ===== rtl/obb_isqrt.sv =====
// ---------------------------------------------------------------------------
// obb_isqrt: pipelined floor square root
// Restoring digit recurrence, a fixed number of root bits per stage.
// ---------------------------------------------------------------------------
module obb_isqrt #(
    parameter int IN_W = 34
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    output logic [IN_W/2-1:0] root
);

    localparam int ROOT_W = IN_W / 2;
    localparam int STEPS  = obb_pkg::SQRT_STEPS_PER_STAGE;
    localparam int STAGES = (ROOT_W + STEPS - 1) / STEPS;

    logic [IN_W-1:0] rem_src  [STAGES];
    logic [IN_W-1:0] res_src  [STAGES];
    logic [IN_W-1:0] rem_next [STAGES];
    logic [IN_W-1:0] res_next [STAGES];
    logic [IN_W-1:0] rem_reg  [STAGES];
    logic [IN_W-1:0] res_reg  [STAGES];

    generate
        for (genvar s = 0; s < STAGES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                assign rem_src[s] = radicand;
                assign res_src[s] = '0;
            end
            else
            begin : g_next
                assign rem_src[s] = rem_reg[s-1];
                assign res_src[s] = res_reg[s-1];
            end

            always_comb
            begin
                logic [IN_W-1:0] rem_v;
                logic [IN_W-1:0] res_v;
                logic [IN_W-1:0] trial;
                rem_v = rem_src[s];
                res_v = res_src[s];
                trial = '0;
                for (int t = 0; t < STEPS; t++)
                begin
                    if (s * STEPS + t < ROOT_W)
                    begin
                        trial = res_v + (IN_W'(1) << (IN_W - 2 - 2 * (s * STEPS + t)));
                        if (rem_v >= trial)
                        begin
                            rem_v = rem_v - trial;
                            res_v = (res_v >> 1)
                                  + (IN_W'(1) << (IN_W - 2 - 2 * (s * STEPS + t)));
                        end
                        else
                        begin
                            res_v = res_v >> 1;
                        end
                    end
                end
                rem_next[s] = rem_v;
                res_next[s] = res_v;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next[s];
                    res_reg[s] <= res_next[s];
                end
            end
        end
    endgenerate

    assign root = res_reg[STAGES-1][ROOT_W-1:0];

endmodule

// ===== rtl/obb_face_axis.sv =====
// ---------------------------------------------------------------------------
// obb_face_axis: separation check along one face axis
// Own radius from the axis length, other radius from projected edges.
// ---------------------------------------------------------------------------
module obb_face_axis #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [2*W+1:0] dots [3],
    input  logic [W-1:0]          sizes [3],
    input  logic [W-1:0]          own_size,
    input  logic [2*W+1:0]        norm_sq,
    input  logic signed [2*W+2:0] center_proj,
    output logic                  sep
);

    localparam int DW        = 2 * W + 2;
    localparam int FPW       = (DW > F) ? DW - F : 1;
    localparam int PRW       = FPW + W;
    localparam int OW        = PRW + 2;
    localparam int LENW      = 2 * W + 3;
    localparam int ROOT_W    = W + 1;
    localparam int OWNW      = 2 * W + 1;
    localparam int STEPS     = obb_pkg::SQRT_STEPS_PER_STAGE;
    localparam int SQ_STAGES = (ROOT_W + STEPS - 1) / STEPS;
    localparam int CMPW      = ((OW > LENW) ? OW : LENW) + 1;

    logic [PRW-1:0]  prod_next [3];
    logic [PRW-1:0]  prod_reg  [3];
    logic [LENW-1:0] len_next;
    logic [LENW-1:0] len4_reg;
    logic [LENW-1:0] len5_reg;
    logic [OW-1:0]   other_next;
    logic [OW-1:0]   other_reg;
    logic [OW-1:0]   other_dly;
    logic [LENW-1:0] len_dly;
    logic [W-1:0]    own_size_dly;
    logic [ROOT_W-1:0] root;
    logic [OWNW-1:0] own_next;
    logic [OWNW-1:0] own_reg;
    logic [OW-1:0]   other6_reg;
    logic [LENW-1:0] len6_reg;
    logic            sep_next;
    logic            sep_reg;

    // project the other box's edges and take the center distance
    always_comb
    begin
        logic [DW-1:0]  mag;
        logic [FPW-1:0] proj;
        mag  = '0;
        proj = '0;
        for (int k = 0; k < 3; k++)
        begin
            mag          = dots[k][DW-1] ? DW'(-dots[k]) : DW'(dots[k]);
            proj         = FPW'(mag >> F);
            prod_next[k] = PRW'(proj) * PRW'(sizes[k]);
        end
        len_next = center_proj[LENW-1] ? LENW'(-center_proj) : LENW'(center_proj);
    end

    assign other_next = OW'(prod_reg[0]) + OW'(prod_reg[1]) + OW'(prod_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            len4_reg  <= len_next;
            other_reg <= other_next;
            len5_reg  <= len4_reg;
        end
    end

    obb_isqrt #(.IN_W(2 * W + 2)) u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (norm_sq),
        .root     (root)
    );

    obb_delay #(.WIDTH(OW), .DEPTH(SQ_STAGES - 2)) u_other_dly (
        .clk  (clk),
        .en   (en),
        .din  (other_reg),
        .dout (other_dly)
    );

    obb_delay #(.WIDTH(LENW), .DEPTH(SQ_STAGES - 2)) u_len_dly (
        .clk  (clk),
        .en   (en),
        .din  (len5_reg),
        .dout (len_dly)
    );

    obb_delay #(.WIDTH(W), .DEPTH(SQ_STAGES)) u_size_dly (
        .clk  (clk),
        .en   (en),
        .din  (own_size),
        .dout (own_size_dly)
    );

    assign own_next = OWNW'(root) * OWNW'(own_size_dly);
    assign sep_next = CMPW'(len6_reg) > (CMPW'(own_reg) + CMPW'(other6_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            own_reg    <= own_next;
            other6_reg <= other_dly;
            len6_reg   <= len_dly;
            sep_reg    <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

// ===== rtl/obb_cross_axis.sv =====
// ---------------------------------------------------------------------------
// obb_cross_axis: separation check along one edge cross product axis
// Four stages: products, dots, edge radii, sum and compare.
// ---------------------------------------------------------------------------
module obb_cross_axis #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  logic clk,
    input  logic en,
    input  logic signed [((2*W+1 > F) ? 2*W+1-F : 1)-1:0] c [3],
    input  logic signed [W-1:0] edges [4][3],
    input  logic signed [W:0]   d [3],
    input  logic [W-1:0]        sizes [4],
    output logic                sep
);

    localparam int CW   = (2 * W + 1 > F) ? 2 * W + 1 - F : 1;
    localparam int EW   = CW + W;
    localparam int EDW  = EW + 2;
    localparam int LW   = EW + 3;
    localparam int PW   = (EDW > F) ? EDW - F : 1;
    localparam int RW   = PW + W;
    localparam int SUMW = RW + 2;
    localparam int CMPW = ((SUMW > LW) ? SUMW : LW) + 1;

    logic signed [EW-1:0] ep_next [4][3];
    logic signed [EW-1:0] ep_reg  [4][3];
    logic signed [EW:0]   dp_next [3];
    logic signed [EW:0]   dp_reg  [3];
    logic [W-1:0]         size4_reg [4];
    logic [W-1:0]         size5_reg [4];
    logic [PW-1:0]        proj_next [4];
    logic [PW-1:0]        proj_reg  [4];
    logic [LW-1:0]        len_next;
    logic [LW-1:0]        len5_reg;
    logic [LW-1:0]        len6_reg;
    logic [RW-1:0]        rp_next [4];
    logic [RW-1:0]        rp_reg  [4];
    logic                 sep_next;
    logic                 sep_reg;

    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                ep_next[e][m] = EW'(c[m]) * EW'(edges[e][m]);
            end
        end
        for (int m = 0; m < 3; m++)
        begin
            dp_next[m] = (EW+1)'(c[m]) * (EW+1)'(d[m]);
        end
    end

    // fold the products into dots and drop the axis fraction bits
    always_comb
    begin
        logic signed [EDW-1:0] dot;
        logic [EDW-1:0]        mag;
        logic signed [LW-1:0]  ddot;
        dot = '0;
        mag = '0;
        for (int e = 0; e < 4; e++)
        begin
            dot          = EDW'(ep_reg[e][0]) + EDW'(ep_reg[e][1]) + EDW'(ep_reg[e][2]);
            mag          = dot[EDW-1] ? EDW'(-dot) : EDW'(dot);
            proj_next[e] = PW'(mag >> F);
        end
        ddot     = LW'(dp_reg[0]) + LW'(dp_reg[1]) + LW'(dp_reg[2]);
        len_next = ddot[LW-1] ? LW'(-ddot) : LW'(ddot);
    end

    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            rp_next[e] = RW'(proj_reg[e]) * RW'(size5_reg[e]);
        end
    end

    assign sep_next = CMPW'(len6_reg) > (CMPW'(rp_reg[0]) + CMPW'(rp_reg[1])
                                       + CMPW'(rp_reg[2]) + CMPW'(rp_reg[3]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ep_reg    <= ep_next;
            dp_reg    <= dp_next;
            size4_reg <= sizes;
            proj_reg  <= proj_next;
            len5_reg  <= len_next;
            size5_reg <= size4_reg;
            rp_reg    <= rp_next;
            len6_reg  <= len5_reg;
            sep_reg   <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

// ===== sim/obb_obb_separating_axis_test_tb.sv =====
// ---------------------------------------------------------------------------
// obb_obb_separating_axis_test_tb: self-checking bench for the box overlap test
// Drives box pairs with random idling, holds off the result side, and
// compares every overlap flag with a bit-exact separating axis predictor.
// ---------------------------------------------------------------------------
module obb_obb_separating_axis_test_tb;

    localparam int W        = obb_pkg::COORD_WIDTH_DEFAULT;
    localparam int FRAC     = obb_pkg::AXIS_FRAC_BITS_DEFAULT;
    localparam int FW       = obb_pkg::FIELD_W;
    localparam int N_RANDOM = 950;
    // marks a directed row whose flag comes from the predictor
    localparam int PREDICT  = 2;
    localparam longint unsigned SAT = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef logic [FW-1:0] field_t;

    typedef struct {
        field_t f[10];
        int     flag;
    } pair_row_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   item_valid = 1'b0;
    logic   item_stall;
    field_t first_center = '0, first_axis_x = '0, first_axis_y = '0, first_axis_z = '0;
    field_t first_half_size = '0, second_center = '0, second_axis_x = '0;
    field_t second_axis_y = '0, second_axis_z = '0, second_half_size = '0;
    logic   result_valid;
    logic   result_stall = 1'b0;
    logic   overlap;

    bit     expected_overlap[$];
    int     mismatches = 0;
    bit     quiet = 1'b0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;

    always #5 clk = ~clk;

    obb_obb_separating_axis_test dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .first_center(first_center), .first_axis_x(first_axis_x),
        .first_axis_y(first_axis_y), .first_axis_z(first_axis_z),
        .first_half_size(first_half_size),
        .second_center(second_center), .second_axis_x(second_axis_x),
        .second_axis_y(second_axis_y), .second_axis_z(second_axis_z),
        .second_half_size(second_half_size),
        .result_valid(result_valid), .result_stall(result_stall),
        .overlap(overlap)
    );

    // -----------------------------------------------------------------------
    // Overlap predictor
    // -----------------------------------------------------------------------
    function automatic longint scomp(field_t v, int k);
        logic [W-1:0] c;
        c = v[k*W +: W];
        return longint'($signed(c));
    endfunction

    function automatic longint unsigned sat_mul(longint unsigned p, longint unsigned q);
        logic [127:0] prod;
        prod = 128'(p) * 128'(q);
        return (prod[127:64] != 0) ? SAT : prod[63:0];
    endfunction

    function automatic longint unsigned sat_add(longint unsigned p, longint unsigned q);
        logic [64:0] s;
        s = 65'(p) + 65'(q);
        return s[64] ? SAT : s[63:0];
    endfunction

    function automatic longint unsigned mag(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    // floor square root, two bits of the operand per step
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint dot(longint p[3], longint q[3]);
        return p[0]*q[0] + p[1]*q[1] + p[2]*q[2];
    endfunction

    // size times the projected length of an axis on the separating direction
    function automatic longint unsigned edge_reach(longint s[3], longint ax[3],
                                                   longint unsigned sz);
        return sat_mul(sz, mag(dot(s, ax)) >> FRAC);
    endfunction

    function automatic bit boxes_overlap(field_t f[10]);
        longint a[3][3], b[3][3], d[3], c[3], ai[3], bj[3], ak[3], bk[3];
        longint unsigned sa[3], sb[3], ra, rb, len;
        bit hit;
        hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            d[k]  = scomp(f[0], k) - scomp(f[5], k);
            sa[k] = longint'(f[4][k*W +: W]);
            sb[k] = longint'(f[9][k*W +: W]);
            for (int i = 0; i < 3; i++) begin
                a[i][k] = scomp(f[1+i], k);
                b[i][k] = scomp(f[6+i], k);
            end
        end
        // face axes of both boxes
        for (int i = 0; i < 3; i++) begin
            ai = a[i];
            bj = b[i];
            ra = sat_mul(sa[i], floor_sqrt(longint'(dot(ai, ai))));
            rb = 0;
            for (int k = 0; k < 3; k++) begin
                bk = b[k];
                rb = sat_add(rb, edge_reach(ai, bk, sb[k]));
            end
            len = mag(dot(d, ai));
            if (len > sat_add(ra, rb)) hit = 1'b0;
            rb = sat_mul(sb[i], floor_sqrt(longint'(dot(bj, bj))));
            ra = 0;
            for (int k = 0; k < 3; k++) begin
                ak = a[k];
                ra = sat_add(ra, edge_reach(bj, ak, sa[k]));
            end
            len = mag(dot(d, bj));
            if (len > sat_add(ra, rb)) hit = 1'b0;
        end
        // cross axes, components floored after the fraction shift
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c[0] = (a[i][1]*b[j][2] - a[i][2]*b[j][1]) >>> FRAC;
                c[1] = (a[i][2]*b[j][0] - a[i][0]*b[j][2]) >>> FRAC;
                c[2] = (a[i][0]*b[j][1] - a[i][1]*b[j][0]) >>> FRAC;
                ra = 0;
                rb = 0;
                for (int k = 0; k < 3; k++) begin
                    ak = a[k];
                    bk = b[k];
                    if (k != i) ra = sat_add(ra, edge_reach(c, ak, sa[k]));
                    if (k != j) rb = sat_add(rb, edge_reach(c, bk, sb[k]));
                end
                len = mag(dot(d, c));
                if (len > sat_add(ra, rb)) hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic field_t pack3(int x, int y, int z);
        logic [W-1:0] cx, cy, cz;
        cx = x[W-1:0];
        cy = y[W-1:0];
        cz = z[W-1:0];
        return field_t'({cz, cy, cx});
    endfunction

    // near-unit axis along component idx with some jitter on every component
    function automatic field_t jitter_axis(int idx, int jit);
        int v[3];
        for (int k = 0; k < 3; k++)
            v[k] = $urandom_range(2*jit) - jit;
        v[idx] += ($urandom_range(1) != 0) ? (1 << FRAC) : -(1 << FRAC);
        return pack3(v[0], v[1], v[2]);
    endfunction

    function automatic void plausible_pair(output field_t f[10]);
        int jit, span, cx, cy, cz, pa, pb;
        jit  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1 << ($urandom_range(12)));
        span = 1 << $urandom_range(6, 12);
        cx = $urandom_range(8000) - 4000;
        cy = $urandom_range(8000) - 4000;
        cz = $urandom_range(8000) - 4000;
        pa = $urandom_range(2);
        pb = $urandom_range(2);
        f[0] = pack3(cx, cy, cz);
        f[5] = pack3(cx + $urandom_range(2*span) - span, cy + $urandom_range(2*span) - span,
                     cz + $urandom_range(2*span) - span);
        for (int i = 0; i < 3; i++) begin
            f[1+i] = jitter_axis((i + pa) % 3, jit);
            f[6+i] = jitter_axis((i + pb) % 3, jit);
        end
        f[4] = pack3($urandom_range(span), $urandom_range(span), $urandom_range(span));
        f[9] = pack3($urandom_range(span), $urandom_range(span), $urandom_range(span));
    endfunction

    function automatic field_t any_field();
        return field_t'({$urandom, $urandom});
    endfunction

    // -----------------------------------------------------------------------
    // Input side: record the expectation on every accepted transfer
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        field_t f[10];
        if (rst_n && item_valid && !item_stall) begin
            f = '{first_center, first_axis_x, first_axis_y, first_axis_z, first_half_size,
                  second_center, second_axis_x, second_axis_y, second_axis_z,
                  second_half_size};
            expected_overlap = {expected_overlap, boxes_overlap(f)};
        end
    end

    task automatic offer_pair(field_t f[10]);
        // idle gaps land on random phases unless the quiet stretch is on
        while (!quiet && $urandom_range(99) < 21) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        first_center     <= f[0];
        first_axis_x     <= f[1];
        first_axis_y     <= f[2];
        first_axis_z     <= f[3];
        first_half_size  <= f[4];
        second_center    <= f[5];
        second_axis_x    <= f[6];
        second_axis_y    <= f[7];
        second_axis_z    <= f[8];
        second_half_size <= f[9];
        item_valid       <= 1'b1;
        // hold the payload until the transfer happens
        do @(posedge clk); while (item_stall);
    endtask

    // -----------------------------------------------------------------------
    // Output side: random stall, one long hold-off on request
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_req && hold_left == 0 && !quiet) begin
            hold_left <= 300;
            hold_req  <= 1'b0;
        end
        if (hold_left > 0) begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else
            result_stall <= !quiet && ($urandom_range(99) < 21);
    end

    always @(posedge clk) begin
        bit want;
        if (rst_n && result_valid && !result_stall) begin
            if (expected_overlap.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: overlap=%0b", overlap);
            end
            else begin
                want = expected_overlap.pop_front();
                if (overlap !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("overlap mismatch: expected %0b, got %0b", want, overlap);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Directed rows, then random pairs
    // -----------------------------------------------------------------------
    initial begin
        pair_row_t rows[$];
        pair_row_t r;
        field_t    f[10];
        field_t    ux, uy, uz, ones;
        int        waited;

        ux   = pack3(1 << FRAC, 0, 0);
        uy   = pack3(0, 1 << FRAC, 0);
        uz   = pack3(0, 0, 1 << FRAC);
        ones = '1;

        // all zero: nothing can exceed a zero radius, so overlap
        r.f = '{default: '0}; r.flag = 1; rows = {rows, r};
        // identical unit boxes: the cross axes of matching edges are zero
        r.f = '{0, ux, uy, uz, pack3(256, 256, 256), 0, ux, uy, uz, pack3(256, 256, 256)};
        r.flag = 1; rows = {rows, r};
        // points at opposite extremes of x with no size: separated on x
        r.f = '{pack3(16'h7FFF, 0, 0), ux, uy, uz, 0, pack3(16'h8000, 0, 0), ux, uy, uz, 0};
        r.flag = 0; rows = {rows, r};
        // touching faces: distance equals summed radii, still overlap
        r.f = '{pack3(512, 0, 0), ux, uy, uz, pack3(256, 256, 256),
                0, ux, uy, uz, pack3(256, 256, 256)};
        r.flag = 1; rows = {rows, r};
        // one step further apart: separated
        r.f = '{pack3(513, 0, 0), ux, uy, uz, pack3(256, 256, 256),
                0, ux, uy, uz, pack3(256, 256, 256)};
        r.flag = 0; rows = {rows, r};
        // remaining rows go to the predictor
        r.flag = PREDICT;
        r.f = '{default: ones}; rows = {rows, r};
        r.f = '{ones, ones, ones, ones, 0, 0, ones, ones, ones, 0}; rows = {rows, r};
        r.f = '{pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), pack3(16'h8000, 16'h8000, 16'h8000),
                pack3(16'h7FFF, 16'h8000, 16'h7FFF), pack3(16'h8000, 16'h7FFF, 16'h8000),
                pack3(16'hFFFF, 16'hFFFF, 16'hFFFF), pack3(16'h8000, 16'h8000, 16'h8000),
                pack3(16'h7FFF, 16'h7FFF, 16'h8000), uy, uz, pack3(16'hFFFF, 0, 16'hFFFF)};
        rows = {rows, r};
        // rotated box B (45 degrees about z), degenerate zero axes on A
        r.f = '{pack3(300, 200, 0), ux, uy, uz, pack3(256, 128, 64), 0,
                pack3(11585, 11585, 0), pack3(-11585, 11585, 0), uz, pack3(256, 256, 256)};
        rows = {rows, r};
        r.f = '{pack3(100, -50, 30), 0, 0, 0, pack3(500, 500, 500), 0,
                pack3(11585, 11585, 0), pack3(-11585, 11585, 0), uz, pack3(64, 64, 64)};
        rows = {rows, r};
        r.f = '{pack3(-700, 400, 0), pack3(3, 1 << FRAC, 0), ux, uz, pack3(100, 200, 300),
                pack3(200, 200, 200), uz, pack3(1 << FRAC, 1 << FRAC, 0), uy, pack3(9, 9, 9)};
        rows = {rows, r};

        #1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[n]) begin
            if (rows[n].flag != PREDICT && boxes_overlap(rows[n].f) != rows[n].flag) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: predictor disagrees with table value %0d",
                             n, rows[n].flag);
            end
            offer_pair(rows[n].f);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 250) hold_req = 1'b1;
            quiet = (n >= 500 && n < 650);
            if ($urandom_range(4) == 0) begin
                foreach (f[k]) f[k] = any_field();
            end
            else
                plausible_pair(f);
            offer_pair(f);
        end
        item_valid <= 1'b0;
        quiet = 1'b0;

        // drain, then let the pipeline settle past its latency
        waited = 0;
        while (expected_overlap.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_overlap.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
